>>> hw/rtl/scan_point_segmenter_core_assert.svh
// Assertion macros used by the scan point segmenter core.
`ifndef SCAN_POINT_SEGMENTER_CORE_ASSERT_SVH
`define SCAN_POINT_SEGMENTER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define SCNSEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SCNSEG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/scnseg_pkg.sv
// Types, constants and arithmetic helpers of the scan point segmenter.
`default_nettype none

package scnseg_pkg;

  localparam int MAX_BEAMS = 1024;
  localparam int IDX_W     = 10;
  // Highest beam index; indices saturate here on an overlong scan.
  localparam int IDX_CAP   = ((MAX_BEAMS < 1024) ? MAX_BEAMS : 1024) - 1;

  localparam int COORD_W = 16;
  localparam int CFG_W   = 12;
  localparam int SQ_W    = 2 * CFG_W;
  localparam int DIST_W  = 33;

  localparam logic [CFG_W-1:0] GAP_THRESHOLD_RST = CFG_W'(200);
  localparam logic [CFG_W-1:0] SIZE_MIN_RST      = CFG_W'(200);
  localparam logic [CFG_W-1:0] SIZE_MAX_RST      = CFG_W'(400);

  typedef enum logic [1:0] {
    CFG_GAP_THRESHOLD = 2'd0,
    CFG_SIZE_MIN      = 2'd1,
    CFG_SIZE_MAX      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_beam;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          end_index;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic [DIST_W-1:0]         size_squared;
    logic                      is_candidate;
    logic                      scan_end;
  } result_t;

  // A closed segment waiting to be measured.
  typedef struct packed {
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          end_index;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      scan_end;
  } seg_rec_t;

  // Squared size window, exclusive on both ends.
  typedef struct packed {
    logic [SQ_W-1:0] min2;
    logic [SQ_W-1:0] max2;
  } size_win_t;

  function automatic logic [DIST_W-1:0] dist_sq(
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by
  );
    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [2*COORD_W+1:0] px;
    logic signed [2*COORD_W+1:0] py;
    dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
    dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
    px = dx * dx;
    py = dy * dy;
    // Each square is below 2^32, so the low 32 bits hold it exactly.
    return DIST_W'(px[2*COORD_W-1:0]) + DIST_W'(py[2*COORD_W-1:0]);
  endfunction

  function automatic logic [SQ_W-1:0] cfg_square(input logic [CFG_W-1:0] v);
    return {{CFG_W{1'b0}}, v} * {{CFG_W{1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scnseg_if.sv
// Channel interfaces of the scan point segmenter: points, results, configuration.
`default_nettype none

interface scnseg_point_if;
  logic                 valid;
  logic                 ready;
  scnseg_pkg::point_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scnseg_result_if;
  logic                 valid;
  logic                 ready;
  scnseg_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scnseg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         index;
  logic [scnseg_pkg::CFG_W-1:0]       wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/scnseg_measure.sv
// Measures a closed segment: midpoint, squared size and candidate flag.
`default_nettype none

module scnseg_measure (
  input  scnseg_pkg::seg_rec_t  rec_i,
  input  scnseg_pkg::size_win_t win_i,
  output scnseg_pkg::result_t   res_o
);

  logic [scnseg_pkg::DIST_W-1:0]         size2;
  logic signed [scnseg_pkg::COORD_W:0]   sum_x;
  logic signed [scnseg_pkg::COORD_W:0]   sum_y;

  assign size2 = scnseg_pkg::dist_sq(rec_i.start_x, rec_i.start_y, rec_i.end_x, rec_i.end_y);

  // Dropping the low bit of the widened sum rounds halves toward minus infinity.
  assign sum_x = {rec_i.start_x[scnseg_pkg::COORD_W-1], rec_i.start_x}
               + {rec_i.end_x[scnseg_pkg::COORD_W-1], rec_i.end_x};
  assign sum_y = {rec_i.start_y[scnseg_pkg::COORD_W-1], rec_i.start_y}
               + {rec_i.end_y[scnseg_pkg::COORD_W-1], rec_i.end_y};

  always_comb begin
    res_o.first_index  = rec_i.first_index;
    res_o.end_index    = rec_i.end_index;
    res_o.mid_x        = sum_x[scnseg_pkg::COORD_W:1];
    res_o.mid_y        = sum_y[scnseg_pkg::COORD_W:1];
    res_o.size_squared = size2;
    res_o.is_candidate = (size2 > scnseg_pkg::DIST_W'(win_i.min2))
                      && (size2 < scnseg_pkg::DIST_W'(win_i.max2));
    res_o.scan_end     = rec_i.scan_end;
  end

endmodule

`default_nettype wire

>>> hw/rtl/scan_point_segmenter_core.sv
// A point passes through the input register, the segment slots and the output register.
// Throughput: one point per cycle while result_o is ready; a point that closes two segments
// stalls the next point, since the single output register drains one result per cycle.
// The rate is set by the registered update of the previous point and segment start.
// Reset (rst_ni low, asynchronous): pipeline empty, segment state and beam count zero,
// registers back to gap 200, size window 200 to 400. No clearing pass.
`default_nettype none
`include "scan_point_segmenter_core_assert.svh"

module scan_point_segmenter_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  scnseg_cfg_if.sink             cfg_i,
  scnseg_point_if.sink           point_i,
  scnseg_result_if.source        result_o
);

  localparam int IDX_W   = scnseg_pkg::IDX_W;
  localparam int COORD_W = scnseg_pkg::COORD_W;
  localparam int SQ_W    = scnseg_pkg::SQ_W;

  // Configuration, kept as squares since every compare is on squared distances.
  logic [SQ_W-1:0] gap2_q;
  logic [SQ_W-1:0] min2_q;
  logic [SQ_W-1:0] max2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap2_q <= scnseg_pkg::cfg_square(scnseg_pkg::GAP_THRESHOLD_RST);
      min2_q <= scnseg_pkg::cfg_square(scnseg_pkg::SIZE_MIN_RST);
      max2_q <= scnseg_pkg::cfg_square(scnseg_pkg::SIZE_MAX_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        scnseg_pkg::CFG_GAP_THRESHOLD: gap2_q <= scnseg_pkg::cfg_square(cfg_i.wdata);
        scnseg_pkg::CFG_SIZE_MIN:      min2_q <= scnseg_pkg::cfg_square(cfg_i.wdata);
        scnseg_pkg::CFG_SIZE_MAX:      max2_q <= scnseg_pkg::cfg_square(cfg_i.wdata);
        default: ;
      endcase
    end
  end

  // Input register.
  logic                s1_v_q;
  scnseg_pkg::point_t  s1_q;
  logic                s2_room;
  logic                s2_load;
  logic                point_acc;

  assign s2_load       = s1_v_q && s2_room;
  assign point_i.ready = !s1_v_q || s2_room;
  assign point_acc     = point_i.valid && point_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (point_acc) begin
      s1_v_q <= 1'b1;
    end else if (s2_load) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_acc) begin
      s1_q <= point_i.data;
    end
  end

  // Segment state.
  logic signed [COORD_W-1:0] prev_x_q;
  logic signed [COORD_W-1:0] prev_y_q;
  logic signed [COORD_W-1:0] start_x_q;
  logic signed [COORD_W-1:0] start_y_q;
  logic [IDX_W-1:0]          start_idx_q;
  logic [IDX_W-1:0]          beam_count_q;

  logic                      first_pt;
  logic                      gap;
  logic signed [COORD_W-1:0] start_x_d;
  logic signed [COORD_W-1:0] start_y_d;
  logic [IDX_W-1:0]          start_idx_d;
  logic [IDX_W-1:0]          beam_count_d;
  scnseg_pkg::seg_rec_t      gap_rec;
  scnseg_pkg::seg_rec_t      last_rec;

  assign first_pt = (beam_count_q == '0);
  assign gap = !first_pt
            && (scnseg_pkg::dist_sq(prev_x_q, prev_y_q, s1_q.point_x, s1_q.point_y)
                >= scnseg_pkg::DIST_W'(gap2_q));

  always_comb begin
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    start_idx_d = start_idx_q;
    if (first_pt || gap) begin
      start_x_d   = s1_q.point_x;
      start_y_d   = s1_q.point_y;
      start_idx_d = beam_count_q;
    end

    if (s1_q.last_beam) begin
      beam_count_d = '0;
    end else if (beam_count_q < IDX_W'(scnseg_pkg::IDX_CAP)) begin
      beam_count_d = beam_count_q + IDX_W'(1);
    end else begin
      beam_count_d = beam_count_q;
    end

    gap_rec.first_index = start_idx_q;
    gap_rec.end_index   = beam_count_q - IDX_W'(1);
    gap_rec.start_x     = start_x_q;
    gap_rec.start_y     = start_y_q;
    gap_rec.end_x       = prev_x_q;
    gap_rec.end_y       = prev_y_q;
    gap_rec.scan_end    = 1'b0;

    last_rec.first_index = start_idx_d;
    last_rec.end_index   = beam_count_q;
    last_rec.start_x     = start_x_d;
    last_rec.start_y     = start_y_d;
    last_rec.end_x       = s1_q.point_x;
    last_rec.end_y       = s1_q.point_y;
    last_rec.scan_end    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_idx_q  <= '0;
      beam_count_q <= '0;
    end else if (s2_load) begin
      prev_x_q     <= s1_q.point_x;
      prev_y_q     <= s1_q.point_y;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      start_idx_q  <= start_idx_d;
      beam_count_q <= beam_count_d;
    end
  end

  // Closed segments of one point: slot 0 closed by a gap, slot 1 by the last beam.
  scnseg_pkg::seg_rec_t rec_q [2];
  logic [1:0]           rec_v_q;
  logic                 out_v_q;
  scnseg_pkg::result_t  out_q;
  logic                 out_room;
  logic                 pop;
  scnseg_pkg::seg_rec_t head;
  scnseg_pkg::result_t  measured;
  scnseg_pkg::size_win_t win;

  assign out_room = !out_v_q || result_o.ready;
  assign pop      = out_room && (rec_v_q != 2'b00);
  assign head     = rec_v_q[0] ? rec_q[0] : rec_q[1];
  // The slots refill once the last pending segment leaves in this cycle.
  assign s2_room  = (rec_v_q == 2'b00) || (pop && (rec_v_q != 2'b11));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_v_q <= 2'b00;
    end else if (s2_load) begin
      rec_v_q <= {s1_q.last_beam, gap};
    end else if (pop) begin
      if (rec_v_q[0]) begin
        rec_v_q[0] <= 1'b0;
      end else begin
        rec_v_q[1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      rec_q[0] <= gap_rec;
      rec_q[1] <= last_rec;
    end
  end

  assign win.min2 = min2_q;
  assign win.max2 = max2_q;

  scnseg_measure u_measure (
    .rec_i (head),
    .win_i (win),
    .res_o (measured)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_room) begin
      out_v_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= measured;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  `SCNSEG_ASSERT_ALWAYS(a_beam_cap, beam_count_q <= IDX_W'(scnseg_pkg::IDX_CAP), "beam count past cap")
  `SCNSEG_ASSERT(a_s1_hold, s1_v_q && !s2_load |=> s1_v_q && $stable(s1_q), "stalled point lost")
  `SCNSEG_ASSERT(a_last_rec, s2_load && s1_q.last_beam |=> rec_v_q[1] && rec_q[1].scan_end, "final segment not queued")
  `SCNSEG_ASSERT(a_scan_restart, s2_load && s1_q.last_beam |=> beam_count_q == '0, "scan did not restart")
  `SCNSEG_ASSERT(a_rec_kept, (rec_v_q != 2'b00) && !pop |=> rec_v_q != 2'b00, "pending segment dropped")

endmodule

`default_nettype wire
